// ===== rtl/rv32ex_pkg.sv =====
// Shared types, constants and instruction codes for the RV32I execute unit.
// No dependencies; the RTL files refer to this package by scoped names, the bench imports it.

package rv32ex_pkg;

    localparam int XLEN        = 32;
    localparam int REG_AW      = 5;
    localparam int NUM_REGS    = 32;
    localparam int DMEM_ADDR_W = 16;   // 65536 data bytes
    localparam int OUTQ_DEPTH  = 4;

    localparam logic [XLEN-1:0] PC_STEP   = 32'd4;
    localparam logic [XLEN-1:0] JALR_MASK = ~32'd1;

    // Instruction kinds
    localparam logic [5:0] ACT_ADD    = 6'd0;
    localparam logic [5:0] ACT_ADDI   = 6'd1;
    localparam logic [5:0] ACT_AND    = 6'd2;
    localparam logic [5:0] ACT_ANDI   = 6'd3;
    localparam logic [5:0] ACT_OR     = 6'd4;
    localparam logic [5:0] ACT_ORI    = 6'd5;
    localparam logic [5:0] ACT_XOR    = 6'd6;
    localparam logic [5:0] ACT_XORI   = 6'd7;
    localparam logic [5:0] ACT_AUIPC  = 6'd8;
    localparam logic [5:0] ACT_BEQ    = 6'd9;
    localparam logic [5:0] ACT_BGE    = 6'd10;
    localparam logic [5:0] ACT_BGEU   = 6'd11;
    localparam logic [5:0] ACT_BLT    = 6'd12;
    localparam logic [5:0] ACT_BLTU   = 6'd13;
    localparam logic [5:0] ACT_BNE    = 6'd14;
    localparam logic [5:0] ACT_EBREAK = 6'd15;
    localparam logic [5:0] ACT_ECALL  = 6'd16;
    localparam logic [5:0] ACT_FENCE  = 6'd17;
    localparam logic [5:0] ACT_JAL    = 6'd18;
    localparam logic [5:0] ACT_JALR   = 6'd19;
    localparam logic [5:0] ACT_LUI    = 6'd20;
    localparam logic [5:0] ACT_LB     = 6'd21;
    localparam logic [5:0] ACT_LBU    = 6'd22;
    localparam logic [5:0] ACT_LH     = 6'd23;
    localparam logic [5:0] ACT_LHU    = 6'd24;
    localparam logic [5:0] ACT_LW     = 6'd25;
    localparam logic [5:0] ACT_PAUSE  = 6'd26;
    localparam logic [5:0] ACT_SBREAK = 6'd27;
    localparam logic [5:0] ACT_SCALL  = 6'd28;
    localparam logic [5:0] ACT_SLT    = 6'd29;
    localparam logic [5:0] ACT_SLTI   = 6'd30;
    localparam logic [5:0] ACT_SLTU   = 6'd31;
    localparam logic [5:0] ACT_SLTIU  = 6'd32;
    localparam logic [5:0] ACT_SLL    = 6'd33;
    localparam logic [5:0] ACT_SLLI   = 6'd34;
    localparam logic [5:0] ACT_SRA    = 6'd35;
    localparam logic [5:0] ACT_SRAI   = 6'd36;
    localparam logic [5:0] ACT_SRL    = 6'd37;
    localparam logic [5:0] ACT_SRLI   = 6'd38;
    localparam logic [5:0] ACT_SUB    = 6'd39;
    localparam logic [5:0] ACT_SB     = 6'd40;
    localparam logic [5:0] ACT_SH     = 6'd41;
    localparam logic [5:0] ACT_SW     = 6'd42;

    // Memory access sizes
    localparam logic [1:0] SIZE_B = 2'd0;
    localparam logic [1:0] SIZE_H = 2'd1;
    localparam logic [1:0] SIZE_W = 2'd2;

    typedef struct packed {
        logic [5:0]             action;
        logic [REG_AW-1:0]      dest_reg;
        logic [REG_AW-1:0]      src1_reg;
        logic [REG_AW-1:0]      src2_reg;
        logic signed [XLEN-1:0] immediate;
    } t_request;

    typedef struct packed {
        logic [XLEN-1:0]   next_pc;
        logic              write_enable;
        logic [REG_AW-1:0] write_index;
        logic [XLEN-1:0]   write_value;
        logic              syscall_request;
    } t_result;

    // Execute stage outcome, carried into the writeback stage
    typedef struct packed {
        logic [XLEN-1:0]   next_pc;
        logic              wr;
        logic [REG_AW-1:0] rd;
        logic [XLEN-1:0]   value;
        logic              sys;
        logic              ld;
        logic              st;
        logic [1:0]        size;
        logic              uns;
        logic [XLEN-1:0]   addr;
        logic [XLEN-1:0]   store_data;
    } t_exec;

    // Data memory port request
    typedef struct packed {
        logic            rd;
        logic            wr;
        logic [XLEN-1:0] addr;
        logic [3:0]      ben;
        logic [XLEN-1:0] wdata;
    } t_mem_req;

endpackage

// ===== rtl/rv32ex_regfile.sv =====
// General register file: 32 x 32, two registered read ports, one write port.
// Depends on rv32ex_pkg. Entries never written read as zero.

module rv32ex_regfile (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_rd_en,
    input  logic [rv32ex_pkg::REG_AW-1:0]      i_raddr1,
    input  logic [rv32ex_pkg::REG_AW-1:0]      i_raddr2,
    output logic [rv32ex_pkg::XLEN-1:0]        o_rdata1,
    output logic [rv32ex_pkg::XLEN-1:0]        o_rdata2,
    input  logic                               i_we,
    input  logic [rv32ex_pkg::REG_AW-1:0]      i_waddr,
    input  logic [rv32ex_pkg::XLEN-1:0]        i_wdata
);

    logic [rv32ex_pkg::XLEN-1:0]     r_mem [rv32ex_pkg::NUM_REGS];
    logic [rv32ex_pkg::NUM_REGS-1:0] r_valid;
    logic [rv32ex_pkg::XLEN-1:0]     r_rdata1;
    logic [rv32ex_pkg::XLEN-1:0]     r_rdata2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Write-through: a read at the edge of a write to the same entry sees the new data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_we && i_waddr == i_raddr1) begin
                r_rdata1 <= i_wdata;
            end else begin
                r_rdata1 <= r_valid[i_raddr1] ? r_mem[i_raddr1] : '0;
            end
            if (i_we && i_waddr == i_raddr2) begin
                r_rdata2 <= i_wdata;
            end else begin
                r_rdata2 <= r_valid[i_raddr2] ? r_mem[i_raddr2] : '0;
            end
        end
    end

    assign o_rdata1 = r_rdata1;
    assign o_rdata2 = r_rdata2;

endmodule

// ===== rtl/rv32ex_dmem.sv =====
// Byte-addressed little-endian data memory in four byte lanes.
// Depends on rv32ex_pkg. Unaligned accesses wrap at the top of the memory.

module rv32ex_dmem #(
    parameter int ADDR_W = rv32ex_pkg::DMEM_ADDR_W
) (
    input  logic                         i_clk,
    input  rv32ex_pkg::t_mem_req         i_req,
    output logic [rv32ex_pkg::XLEN-1:0]  o_rdata
);

    localparam int ROW_W = ADDR_W - 2;
    localparam int ROWS  = 2 ** ROW_W;

    logic [ROW_W-1:0] w_base;
    logic [1:0]       w_off;
    logic [1:0]       r_off;
    logic [3:0][7:0]  w_lane_q;

    assign w_base = i_req.addr[ADDR_W-1:2];
    assign w_off  = i_req.addr[1:0];

    // Lane j holds the access byte (j - offset) mod 4; lanes below the offset
    // belong to the next row.
    for (genvar j = 0; j < 4; j++) begin : g_lane
        localparam logic [1:0] LANE = 2'(j);

        logic [7:0]       r_bank [ROWS];
        logic [7:0]       r_q;
        logic [ROW_W-1:0] w_row;
        logic [1:0]       w_idx;
        logic             w_we;

        assign w_row = w_base + ROW_W'(LANE < w_off);
        assign w_idx = LANE - w_off;
        assign w_we  = i_req.wr && i_req.ben[w_idx];

        always_ff @(posedge i_clk) begin
            if (w_we) begin
                r_bank[w_row] <= i_req.wdata[{w_idx, 3'b000} +: 8];
            end
            if (i_req.rd) begin
                r_q <= r_bank[w_row];
            end
        end

        assign w_lane_q[j] = r_q;
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd) begin
            r_off <= w_off;
        end
    end

    // Rotate the lanes back into access byte order
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            o_rdata[8*i +: 8] = w_lane_q[r_off + 2'(i)];
        end
    end

endmodule

// ===== rtl/rv32ex_exec.sv =====
// Execute stage logic: ALU, compares, shifts, branch and jump targets, load and
// store decode. Depends on rv32ex_pkg. Purely combinational.

module rv32ex_exec (
    input  rv32ex_pkg::t_request          i_req,
    input  logic [rv32ex_pkg::XLEN-1:0]   i_pc,
    input  logic [rv32ex_pkg::XLEN-1:0]   i_rs1,
    input  logic [rv32ex_pkg::XLEN-1:0]   i_rs2,
    output rv32ex_pkg::t_exec             o_exec
);

    logic [rv32ex_pkg::XLEN-1:0] w_imm;
    logic [rv32ex_pkg::XLEN-1:0] w_opb;
    logic [rv32ex_pkg::XLEN-1:0] w_sum;
    logic [rv32ex_pkg::XLEN-1:0] w_diff;
    logic [rv32ex_pkg::XLEN-1:0] w_seq;
    logic [rv32ex_pkg::XLEN-1:0] w_tgt;
    logic [rv32ex_pkg::XLEN-1:0] w_val;
    logic [rv32ex_pkg::XLEN-1:0] w_npc;
    logic [4:0]                  w_shamt;
    logic                        w_use_imm;
    logic                        w_eq;
    logic                        w_ltu;
    logic                        w_lts;
    logic                        w_wr;
    logic                        w_wr_final;
    logic                        w_sys;
    logic                        w_ld;
    logic                        w_st;
    logic                        w_uns;
    logic [1:0]                  w_size;

    assign w_imm = i_req.immediate;

    always_comb begin
        unique case (i_req.action) inside
            rv32ex_pkg::ACT_ADDI, rv32ex_pkg::ACT_ANDI, rv32ex_pkg::ACT_ORI,
            rv32ex_pkg::ACT_XORI, rv32ex_pkg::ACT_SLTI, rv32ex_pkg::ACT_SLTIU,
            rv32ex_pkg::ACT_SLLI, rv32ex_pkg::ACT_SRAI, rv32ex_pkg::ACT_SRLI,
            rv32ex_pkg::ACT_JALR, rv32ex_pkg::ACT_LB, rv32ex_pkg::ACT_LBU,
            rv32ex_pkg::ACT_LH, rv32ex_pkg::ACT_LHU, rv32ex_pkg::ACT_LW,
            rv32ex_pkg::ACT_SB, rv32ex_pkg::ACT_SH, rv32ex_pkg::ACT_SW: begin
                w_use_imm = 1'b1;
            end
            default: begin
                w_use_imm = 1'b0;
            end
        endcase
    end

    assign w_opb   = w_use_imm ? w_imm : i_rs2;
    assign w_sum   = i_rs1 + w_opb;
    assign w_diff  = i_rs1 - i_rs2;
    assign w_eq    = (i_rs1 == w_opb);
    assign w_ltu   = (i_rs1 < w_opb);
    assign w_lts   = ($signed(i_rs1) < $signed(w_opb));
    assign w_shamt = w_opb[4:0];
    assign w_seq   = i_pc + rv32ex_pkg::PC_STEP;
    assign w_tgt   = i_pc + w_imm;

    always_comb begin
        w_npc  = w_seq;
        w_val  = '0;
        w_wr   = 1'b0;
        w_sys  = 1'b0;
        w_ld   = 1'b0;
        w_st   = 1'b0;
        w_uns  = 1'b0;
        w_size = rv32ex_pkg::SIZE_W;
        unique case (i_req.action) inside
            rv32ex_pkg::ACT_ADD, rv32ex_pkg::ACT_ADDI: begin
                w_val = w_sum;
                w_wr  = 1'b1;
            end
            rv32ex_pkg::ACT_AND, rv32ex_pkg::ACT_ANDI: begin
                w_val = i_rs1 & w_opb;
                w_wr  = 1'b1;
            end
            rv32ex_pkg::ACT_OR, rv32ex_pkg::ACT_ORI: begin
                w_val = i_rs1 | w_opb;
                w_wr  = 1'b1;
            end
            rv32ex_pkg::ACT_XOR, rv32ex_pkg::ACT_XORI: begin
                w_val = i_rs1 ^ w_opb;
                w_wr  = 1'b1;
            end
            rv32ex_pkg::ACT_AUIPC: begin
                w_val = w_tgt;
                w_wr  = 1'b1;
            end
            rv32ex_pkg::ACT_BEQ: begin
                if (w_eq) w_npc = w_tgt;
            end
            rv32ex_pkg::ACT_BNE: begin
                if (!w_eq) w_npc = w_tgt;
            end
            rv32ex_pkg::ACT_BLT: begin
                if (w_lts) w_npc = w_tgt;
            end
            rv32ex_pkg::ACT_BGE: begin
                if (!w_lts) w_npc = w_tgt;
            end
            rv32ex_pkg::ACT_BLTU: begin
                if (w_ltu) w_npc = w_tgt;
            end
            rv32ex_pkg::ACT_BGEU: begin
                if (!w_ltu) w_npc = w_tgt;
            end
            rv32ex_pkg::ACT_ECALL: begin
                w_sys = 1'b1;
            end
            rv32ex_pkg::ACT_JAL: begin
                w_val = w_seq;
                w_wr  = 1'b1;
                w_npc = w_tgt;
            end
            rv32ex_pkg::ACT_JALR: begin
                w_val = w_seq;
                w_wr  = 1'b1;
                w_npc = w_sum & rv32ex_pkg::JALR_MASK;
            end
            rv32ex_pkg::ACT_LUI: begin
                w_val = w_imm;
                w_wr  = 1'b1;
            end
            rv32ex_pkg::ACT_LB, rv32ex_pkg::ACT_LBU: begin
                w_ld   = 1'b1;
                w_wr   = 1'b1;
                w_size = rv32ex_pkg::SIZE_B;
                w_uns  = (i_req.action == rv32ex_pkg::ACT_LBU);
            end
            rv32ex_pkg::ACT_LH, rv32ex_pkg::ACT_LHU: begin
                w_ld   = 1'b1;
                w_wr   = 1'b1;
                w_size = rv32ex_pkg::SIZE_H;
                w_uns  = (i_req.action == rv32ex_pkg::ACT_LHU);
            end
            rv32ex_pkg::ACT_LW: begin
                w_ld   = 1'b1;
                w_wr   = 1'b1;
            end
            rv32ex_pkg::ACT_SLT, rv32ex_pkg::ACT_SLTI: begin
                w_val = {31'b0, w_lts};
                w_wr  = 1'b1;
            end
            rv32ex_pkg::ACT_SLTU, rv32ex_pkg::ACT_SLTIU: begin
                w_val = {31'b0, w_ltu};
                w_wr  = 1'b1;
            end
            rv32ex_pkg::ACT_SLL, rv32ex_pkg::ACT_SLLI: begin
                w_val = i_rs1 << w_shamt;
                w_wr  = 1'b1;
            end
            rv32ex_pkg::ACT_SRL, rv32ex_pkg::ACT_SRLI: begin
                w_val = i_rs1 >> w_shamt;
                w_wr  = 1'b1;
            end
            rv32ex_pkg::ACT_SRA, rv32ex_pkg::ACT_SRAI: begin
                w_val = $unsigned($signed(i_rs1) >>> w_shamt);
                w_wr  = 1'b1;
            end
            rv32ex_pkg::ACT_SUB: begin
                w_val = w_diff;
                w_wr  = 1'b1;
            end
            rv32ex_pkg::ACT_SB: begin
                w_st   = 1'b1;
                w_size = rv32ex_pkg::SIZE_B;
            end
            rv32ex_pkg::ACT_SH: begin
                w_st   = 1'b1;
                w_size = rv32ex_pkg::SIZE_H;
            end
            rv32ex_pkg::ACT_SW: begin
                w_st   = 1'b1;
            end
            default: begin
                // EBREAK, FENCE, PAUSE, SBREAK, SCALL and unused codes: advance only
                w_npc = w_seq;
            end
        endcase
    end

    // Drop writes to x0
    assign w_wr_final = w_wr && (i_req.dest_reg != '0);

    always_comb begin
        o_exec            = '0;
        o_exec.next_pc    = w_npc;
        o_exec.wr         = w_wr_final;
        o_exec.rd         = w_wr_final ? i_req.dest_reg : '0;
        o_exec.value      = w_wr_final ? w_val : '0;
        o_exec.sys        = w_sys;
        o_exec.ld         = w_ld;
        o_exec.st         = w_st;
        o_exec.size       = w_size;
        o_exec.uns        = w_uns;
        o_exec.addr       = w_sum;
        o_exec.store_data = i_rs2;
    end

endmodule

// ===== rtl/rv32ex_outq.sv =====
// Result queue between the writeback stage and the output channel.
// Depends on rv32ex_pkg. Reports its fill level for admission control.

module rv32ex_outq (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  rv32ex_pkg::t_result      i_data,
    output logic                     o_valid,
    input  logic                     i_stall,
    output rv32ex_pkg::t_result      o_data,
    output logic [$clog2(rv32ex_pkg::OUTQ_DEPTH+1)-1:0] o_count
);

    localparam int DEPTH = rv32ex_pkg::OUTQ_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    rv32ex_pkg::t_result r_slot [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]    r_count;
    logic                w_pop;

    assign o_valid = (r_count != '0);
    assign w_pop   = o_valid && !i_stall;
    assign o_data  = r_slot[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (w_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/rv32i_execute_unit_top.sv =====
// RV32I execute unit, top level. An accepted request passes the execute register and
// the writeback register into the result queue, from which its result is offered.
// Throughput: one request per cycle while o_stall is low; the four-entry result queue reserves
// a slot per request in flight, so at full rate an output stall also stalls the input.
// Reset (synchronous, active low): clears PC, retired count, register file
// valid bits (all registers read zero), pipeline valids and queue; data memory is not cleared.

module rv32i_execute_unit_top #(
    parameter int MEM_ADDR_W = rv32ex_pkg::DMEM_ADDR_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  rv32ex_pkg::t_request  i_req,
    output logic                  o_valid,
    input  logic                  i_stall,
    output rv32ex_pkg::t_result   o_res
);

    localparam int CNT_W  = $clog2(rv32ex_pkg::OUTQ_DEPTH + 1);
    localparam int FILL_W = CNT_W + 1;

    // Pipeline: request register (execute) -> writeback register -> result queue.
    // Stages never stall; admission is limited so every request in flight has a
    // queue slot waiting for it.

    logic                        w_accept;
    logic                        r_ex_valid;
    rv32ex_pkg::t_request        r_ex_req;
    logic                        r_wb_valid;
    rv32ex_pkg::t_exec           r_wb;
    logic [rv32ex_pkg::XLEN-1:0] r_pc;
    logic [63:0]                 r_retired;

    logic [rv32ex_pkg::XLEN-1:0] w_rf1;
    logic [rv32ex_pkg::XLEN-1:0] w_rf2;
    logic [rv32ex_pkg::XLEN-1:0] w_opa;
    logic [rv32ex_pkg::XLEN-1:0] w_opb;
    rv32ex_pkg::t_exec           w_exec;
    rv32ex_pkg::t_mem_req        w_mem;
    logic [rv32ex_pkg::XLEN-1:0] w_ld_word;
    logic [rv32ex_pkg::XLEN-1:0] w_ld_val;
    logic [rv32ex_pkg::XLEN-1:0] w_wb_value;
    rv32ex_pkg::t_result         w_wb_res;
    logic [CNT_W-1:0]            w_q_count;
    logic [FILL_W-1:0]           w_fill;

    // ---------------------------------------------------------------
    // Admission: hold off requests while the queue plus both stages could
    // fill every queue slot.
    // ---------------------------------------------------------------
    assign w_fill   = FILL_W'(w_q_count) + FILL_W'(r_ex_valid) + FILL_W'(r_wb_valid);
    assign o_stall  = !i_rst_n || (w_fill >= FILL_W'(rv32ex_pkg::OUTQ_DEPTH));
    assign w_accept = i_valid && !o_stall;

    // Register file: read the sources at the accepting edge, write at the end of writeback
    rv32ex_regfile u_regfile (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (w_accept),
        .i_raddr1 (i_req.src1_reg),
        .i_raddr2 (i_req.src2_reg),
        .o_rdata1 (w_rf1),
        .o_rdata2 (w_rf2),
        .i_we     (r_wb_valid && r_wb.wr),
        .i_waddr  (r_wb.rd),
        .i_wdata  (w_wb_value)
    );

    // ---------------------------------------------------------------
    // Execute stage. The previous request sits in writeback and has not yet
    // reached the register file: forward its value, load data included.
    // ---------------------------------------------------------------
    always_comb begin
        if (r_wb_valid && r_wb.wr && r_wb.rd == r_ex_req.src1_reg) begin
            w_opa = w_wb_value;
        end else begin
            w_opa = w_rf1;
        end
        if (r_wb_valid && r_wb.wr && r_wb.rd == r_ex_req.src2_reg) begin
            w_opb = w_wb_value;
        end else begin
            w_opb = w_rf2;
        end
    end

    rv32ex_exec u_exec (
        .i_req  (r_ex_req),
        .i_pc   (r_pc),
        .i_rs1  (w_opa),
        .i_rs2  (w_opb),
        .o_exec (w_exec)
    );

    // Issue the memory access from execute: stores land at the end of the stage,
    // load data arrives registered for writeback.
    always_comb begin
        w_mem       = '0;
        w_mem.rd    = r_ex_valid && w_exec.ld;
        w_mem.wr    = r_ex_valid && w_exec.st;
        w_mem.addr  = w_exec.addr;
        w_mem.wdata = w_exec.store_data;
        case (w_exec.size)
            rv32ex_pkg::SIZE_B: w_mem.ben = 4'b0001;
            rv32ex_pkg::SIZE_H: w_mem.ben = 4'b0011;
            default:            w_mem.ben = 4'b1111;
        endcase
    end

    rv32ex_dmem #(
        .ADDR_W (MEM_ADDR_W)
    ) u_dmem (
        .i_clk   (i_clk),
        .i_req   (w_mem),
        .o_rdata (w_ld_word)
    );

    // Advance PC and retired count as each request leaves execute
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_valid <= 1'b0;
            r_wb_valid <= 1'b0;
            r_pc       <= '0;
            r_retired  <= '0;
        end else begin
            r_ex_valid <= w_accept;
            r_wb_valid <= r_ex_valid;
            if (r_ex_valid) begin
                r_pc      <= w_exec.next_pc;
                r_retired <= r_retired + 64'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ex_req <= i_req;
        end
        if (r_ex_valid) begin
            r_wb <= w_exec;
        end
    end

    // ---------------------------------------------------------------
    // Writeback stage: size and extend load data, drop the value when no
    // register is written.
    // ---------------------------------------------------------------
    always_comb begin
        case (r_wb.size)
            rv32ex_pkg::SIZE_B: begin
                w_ld_val = r_wb.uns ? {24'b0, w_ld_word[7:0]}
                                    : {{24{w_ld_word[7]}}, w_ld_word[7:0]};
            end
            rv32ex_pkg::SIZE_H: begin
                w_ld_val = r_wb.uns ? {16'b0, w_ld_word[15:0]}
                                    : {{16{w_ld_word[15]}}, w_ld_word[15:0]};
            end
            default: begin
                w_ld_val = w_ld_word;
            end
        endcase
    end

    assign w_wb_value = !r_wb.wr ? '0 : (r_wb.ld ? w_ld_val : r_wb.value);

    always_comb begin
        w_wb_res                 = '0;
        w_wb_res.next_pc         = r_wb.next_pc;
        w_wb_res.write_enable    = r_wb.wr;
        w_wb_res.write_index     = r_wb.rd;
        w_wb_res.write_value     = w_wb_value;
        w_wb_res.syscall_request = r_wb.sys;
    end

    rv32ex_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_wb_valid),
        .i_data  (w_wb_res),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_res),
        .o_count (w_q_count)
    );

`ifndef SYNTHESIS
    // Admission control must keep a queue slot for every request in flight
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fill <= FILL_W'(rv32ex_pkg::OUTQ_DEPTH))
        else $error("result queue overcommitted");

    // x0 is never reported as written
    a_no_x0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_valid && r_wb.wr |-> r_wb.rd != '0)
        else $error("write to x0 reached writeback");

    // A result without a register write carries zero index and value
    a_quiet_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_res.write_enable |-> o_res.write_index == '0 && o_res.write_value == '0)
        else $error("result without write carries data");

    // PC and retired count move only when a request leaves execute
    a_pc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ex_valid |=> $stable(r_pc) && $stable(r_retired))
        else $error("architectural state moved with execute empty");
`endif

endmodule

// ===== bench/rv32i_execute_unit_top_tb.sv =====
// Self-checking bench for rv32i_execute_unit_top: streams decoded RV32I requests,
// predicts every result from a private architectural model and compares them.
// Depends on rv32ex_pkg and rv32i_execute_unit_top; needs no files or arguments.

module rv32i_execute_unit_top_tb;
    import rv32ex_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int IDLE_LIMIT   = 2000;  // cycles with no handshake on either side
    localparam int TAIL_CYCLES  = 10;    // wait after the last drain for a stray result
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_ITEMS = 420;
    localparam int HOLD_CYCLES  = 120;   // long receiver hold-off for the fill test

    // Kinds above SW are unassigned and execute as plain PC advances
    localparam logic [5:0] ACT_UNUSED_MAX = 6'h3F;

    // Favored store targets: a small window low in memory and the top edge
    localparam logic [DMEM_ADDR_W-1:0] STORE_WINDOW = 16'h0100;
    localparam logic [DMEM_ADDR_W-1:0] MEM_TOP_WORD = 16'hFFFC;

    typedef struct {
        logic [DMEM_ADDR_W-1:0] base;
        int                     nbytes;
    } t_store_span;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_stall;
    t_request i_req;
    logic     o_valid;
    logic     i_stall;
    t_result  o_res;

    // Architectural state as the testbench sees it
    logic [XLEN-1:0] arch_pc;
    logic [XLEN-1:0] arch_regs [NUM_REGS];
    logic [7:0]      arch_mem [logic [DMEM_ADDR_W-1:0]];
    t_store_span     store_spans [$];   // every span ever written, so loads stay defined

    t_result expected_results [$];
    int      mismatch_count   = 0;

    // Knobs shared between the test tasks, the request task and the result sink process
    bit src_no_gaps      = 1'b0;
    bit sink_no_stalls   = 1'b0;
    int sink_hold_cycles = 0;
    bit sink_holding     = 1'b0;

    rv32i_execute_unit_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Architectural model
    // ------------------------------------------------------------------

    // Gather bytes little-endian; each byte address wraps at the memory size
    function automatic logic [XLEN-1:0] mem_load(input logic [XLEN-1:0] addr, input int nbytes);
        logic [XLEN-1:0] v;
        int              i;
        v = '0;
        for (i = 0; i < nbytes; i++)
            v[8*i +: 8] = arch_mem[addr[DMEM_ADDR_W-1:0] + DMEM_ADDR_W'(i)];
        return v;
    endfunction

    function automatic void mem_store(input logic [XLEN-1:0] addr, input logic [XLEN-1:0] data,
                                      input int nbytes);
        int i;
        for (i = 0; i < nbytes; i++)
            arch_mem[addr[DMEM_ADDR_W-1:0] + DMEM_ADDR_W'(i)] = data[8*i +: 8];
        store_spans.push_back('{addr[DMEM_ADDR_W-1:0], nbytes});
    endfunction

    // Execute one request against the model state and return its result
    function automatic t_result execute_instr(input t_request r);
        t_result         res;
        logic [XLEN-1:0] a;
        logic [XLEN-1:0] b;
        logic [XLEN-1:0] imm;
        logic [XLEN-1:0] seq;
        logic [XLEN-1:0] npc;
        logic [XLEN-1:0] addr;
        logic [XLEN-1:0] val;
        logic            wr;
        logic            sys;
        a    = arch_regs[r.src1_reg];
        b    = arch_regs[r.src2_reg];
        imm  = r.immediate;
        seq  = arch_pc + PC_STEP;
        npc  = seq;
        addr = a + imm;
        val  = '0;
        wr   = 1'b0;
        sys  = 1'b0;
        case (r.action)
            ACT_ADD:   begin val = a + b;         wr = 1'b1; end
            ACT_ADDI:  begin val = a + imm;       wr = 1'b1; end
            ACT_AND:   begin val = a & b;         wr = 1'b1; end
            ACT_ANDI:  begin val = a & imm;       wr = 1'b1; end
            ACT_OR:    begin val = a | b;         wr = 1'b1; end
            ACT_ORI:   begin val = a | imm;       wr = 1'b1; end
            ACT_XOR:   begin val = a ^ b;         wr = 1'b1; end
            ACT_XORI:  begin val = a ^ imm;       wr = 1'b1; end
            ACT_AUIPC: begin val = arch_pc + imm; wr = 1'b1; end
            ACT_BEQ:   if (a == b) npc = arch_pc + imm;
            ACT_BGE:   if ($signed(a) >= $signed(b)) npc = arch_pc + imm;
            ACT_BGEU:  if (a >= b) npc = arch_pc + imm;
            ACT_BLT:   if ($signed(a) < $signed(b)) npc = arch_pc + imm;
            ACT_BLTU:  if (a < b) npc = arch_pc + imm;
            ACT_BNE:   if (a != b) npc = arch_pc + imm;
            ACT_ECALL: sys = 1'b1;
            ACT_JAL: begin
                val = seq;
                wr  = 1'b1;
                npc = arch_pc + imm;
            end
            ACT_JALR: begin
                val = seq;
                wr  = 1'b1;
                npc = (a + imm) & JALR_MASK;
            end
            ACT_LUI: begin val = imm; wr = 1'b1; end
            ACT_LB: begin
                val = mem_load(addr, 1);
                val = {{24{val[7]}}, val[7:0]};
                wr  = 1'b1;
            end
            ACT_LBU: begin val = mem_load(addr, 1); wr = 1'b1; end
            ACT_LH: begin
                val = mem_load(addr, 2);
                val = {{16{val[15]}}, val[15:0]};
                wr  = 1'b1;
            end
            ACT_LHU:   begin val = mem_load(addr, 2); wr = 1'b1; end
            ACT_LW:    begin val = mem_load(addr, 4); wr = 1'b1; end
            ACT_SLT:   begin val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;   wr = 1'b1; end
            ACT_SLTI:  begin val = ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0; wr = 1'b1; end
            ACT_SLTU:  begin val = (a < b) ? 32'd1 : 32'd0;                     wr = 1'b1; end
            ACT_SLTIU: begin val = (a < imm) ? 32'd1 : 32'd0;                   wr = 1'b1; end
            ACT_SLL:   begin val = a << b[4:0];              wr = 1'b1; end
            ACT_SLLI:  begin val = a << imm[4:0];            wr = 1'b1; end
            ACT_SRA:   begin val = $signed(a) >>> b[4:0];    wr = 1'b1; end
            ACT_SRAI:  begin val = $signed(a) >>> imm[4:0];  wr = 1'b1; end
            ACT_SRL:   begin val = a >> b[4:0];              wr = 1'b1; end
            ACT_SRLI:  begin val = a >> imm[4:0];            wr = 1'b1; end
            ACT_SUB:   begin val = a - b;                    wr = 1'b1; end
            ACT_SB:    mem_store(addr, b, 1);
            ACT_SH:    mem_store(addr, b, 2);
            ACT_SW:    mem_store(addr, b, 4);
            default: ;  // EBREAK, FENCE, PAUSE, SBREAK, SCALL and unused kinds: advance only
        endcase
        // x0 swallows writes; a dropped write reports index and value as zero
        if (wr && r.dest_reg != '0) begin
            arch_regs[r.dest_reg] = val;
        end else begin
            wr  = 1'b0;
            val = '0;
        end
        arch_pc             = npc;
        res.next_pc         = npc;
        res.write_enable    = wr;
        res.write_index     = wr ? r.dest_reg : '0;
        res.write_value     = val;
        res.syscall_request = sys;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_request make_req(input logic [5:0] act, input logic [4:0] rd,
                                          input logic [4:0] rs1, input logic [4:0] rs2,
                                          input logic [XLEN-1:0] imm);
        t_request r;
        r.action    = act;
        r.dest_reg  = rd;
        r.src1_reg  = rs1;
        r.src2_reg  = rs2;
        r.immediate = imm;
        return r;
    endfunction

    // Draw one request. Loads are aimed only at bytes some store has written;
    // stores favor a small window and the top edge so loads find overlaps.
    function automatic t_request random_instr();
        t_request               r;
        t_store_span            span;
        logic [DMEM_ADDR_W-1:0] target;
        int                     roll;
        int                     pick;
        int                     sz;
        roll        = $urandom_range(0, 99);
        r.action    = 6'($urandom_range(0, ACT_SW));
        r.dest_reg  = 5'($urandom);
        r.src1_reg  = 5'($urandom);
        r.src2_reg  = 5'($urandom);
        r.immediate = $urandom;
        // equal operands now and then so BEQ/BGE/BGEU take and BNE falls through
        if ($urandom_range(0, 9) == 0)
            r.src2_reg = r.src1_reg;
        if (roll < 8) begin
            r.action = 6'($urandom_range(ACT_SW + 1, ACT_UNUSED_MAX));
        end else if (roll < 24) begin
            case ($urandom_range(0, 2))
                0:       r.action = ACT_SB;
                1:       r.action = ACT_SH;
                default: r.action = ACT_SW;
            endcase
            pick = $urandom_range(0, 3);
            if (pick < 3) begin
                target = (pick < 2) ? STORE_WINDOW + DMEM_ADDR_W'($urandom_range(0, 63))
                                    : MEM_TOP_WORD + DMEM_ADDR_W'($urandom_range(0, 3));
                r.immediate = {16'($urandom), target - arch_regs[r.src1_reg][15:0]};
            end
        end else if (roll < 40 && store_spans.size() != 0) begin
            span = store_spans[$urandom_range(0, store_spans.size() - 1)];
            pick = $urandom_range(0, span.nbytes == 1 ? 1 : span.nbytes == 2 ? 3 : 4);
            case (pick)
                0:       begin r.action = ACT_LB;  sz = 1; end
                1:       begin r.action = ACT_LBU; sz = 1; end
                2:       begin r.action = ACT_LH;  sz = 2; end
                3:       begin r.action = ACT_LHU; sz = 2; end
                default: begin r.action = ACT_LW;  sz = 4; end
            endcase
            target      = span.base + DMEM_ADDR_W'($urandom_range(0, span.nbytes - sz));
            r.immediate = {16'($urandom), target - arch_regs[r.src1_reg][15:0]};
        end else if (r.action inside {[ACT_LB:ACT_LW]}) begin
            // never read a byte nobody wrote
            r.action = ACT_ADDI;
        end
        return r;
    endfunction

    // Offer one request, wait for the handshake, record its prediction,
    // then idle the source for a random gap (none when back to back)
    task automatic send_request(input t_request r);
        int roll;
        int gap;
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_stall);
        expected_results.push_back(execute_instr(r));
        roll = $urandom_range(0, 99);
        if (src_no_gaps || roll < 55)
            gap = 0;
        else if (roll < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 30);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every predicted result has come back.
    // Valid is still high only right after a handshake, when a result is
    // pending, so the loop always advances time in that case.
    task automatic drain_results();
        if (i_valid)
            i_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Operand extremes, shift-amount masking and the x0 sink
    task automatic test_alu_extremes();
        send_request(make_req(ACT_ADD,   5, 31, 30, 32'h0));          // all registers zero
        send_request(make_req(ACT_ADDI,  1,  0,  0, 32'h8000_0000));
        send_request(make_req(ACT_ADDI,  2,  0,  0, 32'hFFFF_FFFF));
        send_request(make_req(ACT_LUI,  31, 31, 31, 32'hFFFF_F000));
        send_request(make_req(ACT_SUB,   6,  1,  2, 32'h0));          // wraps
        send_request(make_req(ACT_SLT,   7,  1,  2, 32'h0));          // most negative < -1
        send_request(make_req(ACT_SLTIU, 8,  1,  0, 32'hFFFF_FFFF));
        send_request(make_req(ACT_SRA,   9,  1,  2, 32'h0));          // shift by 31
        send_request(make_req(ACT_SRLI, 10,  1,  0, 32'hFFFF_FFE1));  // low five bits only
        send_request(make_req(ACT_XORI,  0,  2,  0, 32'h7FFF_FFFF));  // write to x0 dropped
        drain_results();
    endtask

    // Sign and zero extension, and accesses that wrap past the top byte
    task automatic test_memory_wrap();
        send_request(make_req(ACT_ADDI, 12, 0,  0, 32'h80FF_7F01));
        send_request(make_req(ACT_SW,    0, 0, 12, 32'h1234_FFFE));   // FFFE..0001
        send_request(make_req(ACT_LW,   13, 0,  0, 32'hFFFF_FFFE));
        send_request(make_req(ACT_LB,   14, 0,  0, 32'h0000_FFFF));
        send_request(make_req(ACT_LBU,  15, 0,  0, 32'hFFFF_0000));
        send_request(make_req(ACT_LH,   16, 0,  0, 32'h0000_0000));
        send_request(make_req(ACT_LHU,  17, 0,  0, 32'h0001_FFFF));   // wraps to 0000
        send_request(make_req(ACT_SH,    0, 0,  2, 32'h0000_0001));
        send_request(make_req(ACT_SB,    0, 0,  1, 32'h8000_0003));
        send_request(make_req(ACT_LW,   18, 0,  0, 32'h0000_0000));
        drain_results();
    endtask

    // Taken and untaken branches, jumps, JALR bit clearing and system kinds
    task automatic test_control_flow();
        send_request(make_req(ACT_BLT,   0, 1, 2, 32'hFFFF_FFF8));    // taken, backward
        send_request(make_req(ACT_BGEU,  0, 1, 2, 32'h0000_0100));    // not taken
        send_request(make_req(ACT_JAL,  19, 0, 0, 32'h7FFF_FFFE));
        send_request(make_req(ACT_JALR, 20, 2, 0, 32'h0000_0004));    // odd target
        send_request(make_req(ACT_AUIPC, 21, 0, 0, 32'h8000_0000));
        send_request(make_req(ACT_ECALL, 0, 0, 0, 32'h0));
        send_request(make_req(ACT_FENCE, 3, 1, 2, 32'hFFFF_FFFF));
        send_request(make_req(ACT_UNUSED_MAX, 31, 31, 31, 32'hFFFF_FFFF));
        drain_results();
    endtask

    // Hold the result side off for a long stretch while requests keep
    // coming, so the result queue fills and the input stalls
    task automatic test_output_backpressure();
        sink_hold_cycles = HOLD_CYCLES;
        while (!sink_holding)
            @(posedge i_clk);
        src_no_gaps = 1'b1;
        repeat (16) send_request(random_instr());
        src_no_gaps = 1'b0;
        drain_results();
    endtask

    // Full rate on both sides: one request and one result per cycle while neither side stalls
    task automatic test_back_to_back();
        src_no_gaps    = 1'b1;
        sink_no_stalls = 1'b1;
        repeat (40) send_request(random_instr());
        src_no_gaps    = 1'b0;
        sink_no_stalls = 1'b0;
        drain_results();
    endtask

    task automatic test_random_program();
        repeat (RANDOM_ITEMS) send_request(random_instr());
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, the long hold-off, and the checker
    // ------------------------------------------------------------------

    initial begin : result_sink
        int roll;
        int run;
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            roll = $urandom_range(0, 99);
            if (sink_hold_cycles > 0) begin
                run              = sink_hold_cycles;
                sink_hold_cycles = 0;
                sink_holding     = 1'b1;
                i_stall <= 1'b1;
            end else if (sink_no_stalls || roll < 65) begin
                run = $urandom_range(1, 6);
                i_stall <= 1'b0;
            end else if (roll < 94) begin
                run = $urandom_range(1, 3);
                i_stall <= 1'b1;
            end else begin
                run = $urandom_range(8, 30);
                i_stall <= 1'b1;
            end
            repeat (run) @(posedge i_clk);
            sink_holding = 1'b0;
        end
    end

    task automatic report_mismatch(input string what, input t_result want, input t_result got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%s: expected pc=%h we=%b idx=%0d val=%h sys=%b",
                     what, want.next_pc, want.write_enable, want.write_index,
                     want.write_value, want.syscall_request,
                     "  got pc=%h we=%b idx=%0d val=%h sys=%b",
                     got.next_pc, got.write_enable, got.write_index,
                     got.write_value, got.syscall_request);
    endtask

    // Sample at the edge, before any of this step's updates land
    initial begin : result_check
        t_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing pending", '0, o_res);
                end else begin
                    want = expected_results.pop_front();
                    if (o_res.next_pc !== want.next_pc
                            || o_res.write_enable !== want.write_enable
                            || o_res.write_index !== want.write_index
                            || o_res.write_value !== want.write_value
                            || o_res.syscall_request !== want.syscall_request)
                        report_mismatch("result mismatch", want, o_res);
                end
            end
        end
    end

    // End the run if neither side moves for too long
    initial begin : watchdog
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", idle);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_req   <= '0;
        arch_pc = '0;
        foreach (arch_regs[k])
            arch_regs[k] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_alu_extremes();
        test_memory_wrap();
        test_control_flow();
        test_output_backpressure();
        test_back_to_back();
        test_random_program();

        // Give a stray extra result time to show up before judging
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
